### rtl/core/rpnp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rpnp_pkg
// Shared types, sizes and generator constants of the note pool core.
// ============================================================================
package rpnp_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int NOTE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [63:0] PCG_MULT   = 64'd6364136223846793005;
    localparam logic [63:0] PCG_STREAM = 64'hda3e39cb94b95bdb;
    localparam logic [63:0] PCG_INC    = {PCG_STREAM[62:0], 1'b1};
    // state after seeding with a zero seed
    localparam logic [63:0] PCG_RESET_STATE = PCG_INC * PCG_MULT + PCG_INC;

    typedef enum logic [1:0] {
        CMD_NOTE  = 2'd0,
        CMD_PICK  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REMOVE_MODE = 2'd0,
        CFG_SEED        = 2'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_LOAD,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [NOTE_W-1:0]  note;
        logic [CNT_W-1:0]          pos;
        logic [CNT_W-1:0]          count;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_RANGE,
        ST_LIMIT,
        ST_GEN,
        ST_INDEX,
        ST_SHIFT,
        ST_FIN
    } state_t;

endpackage

### rtl/core/rpnp_if.sv
`timescale 1ns / 1ps
// ============================================================================
// rpnp_if
// Request, result and configuration channels of the note pool core.
// ============================================================================
interface rpnp_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            cmd;
    logic signed [rpnp_pkg::NOTE_W-1:0]    note;
    logic                                  list_start;
    modport source (output valid, cmd, note, list_start, input ready);
    modport sink   (input valid, cmd, note, list_start, output ready);
endinterface

interface rpnp_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rpnp_pkg::NOTE_W-1:0]    picked_note;
    logic                                  pick_valid;
    logic [rpnp_pkg::CNT_W-1:0]            entry_count;
    logic                                  note_found;
    logic                                  overflow;
    modport source (output valid, picked_note, pick_valid, entry_count, note_found,
                    overflow, input ready);
    modport sink   (input valid, picked_note, pick_valid, entry_count, note_found,
                    overflow, output ready);
endinterface

interface rpnp_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [rpnp_pkg::CFG_IDX_W-1:0]        index;
    logic [rpnp_pkg::CFG_DATA_W-1:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/rpnp_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// rpnp_cell
// One pool slot: holds an entry and a read tap, trades with its neighbors.
// ============================================================================
module rpnp_cell (
    input  logic                                clk,
    input  logic [rpnp_pkg::IDX_W-1:0]          cell_idx,
    input  rpnp_pkg::cell_ctrl_t                ctrl,
    input  logic signed [rpnp_pkg::NOTE_W-1:0]  left_entry,
    input  logic signed [rpnp_pkg::NOTE_W-1:0]  right_entry,
    input  logic signed [rpnp_pkg::NOTE_W-1:0]  right_tap,
    input  logic                                seen_in,
    output logic                                seen_out,
    output logic signed [rpnp_pkg::NOTE_W-1:0]  entry,
    output logic signed [rpnp_pkg::NOTE_W-1:0]  tap
);
    import rpnp_pkg::*;

    logic signed [NOTE_W-1:0] entry_reg, entry_next;
    logic signed [NOTE_W-1:0] tap_reg, tap_next;
    logic [CNT_W-1:0]         my_pos;
    logic                     match;

    assign my_pos   = {{(CNT_W-IDX_W){1'b0}}, cell_idx};
    assign match    = (entry_reg == ctrl.note) && (my_pos < ctrl.count);
    assign seen_out = seen_in | match;

    always_comb
    begin
        entry_next = entry_reg;
        tap_next   = tap_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (my_pos == ctrl.pos)
                    entry_next = ctrl.note;
                else if (my_pos > ctrl.pos && my_pos <= ctrl.count)
                    entry_next = left_entry;
            end
            CELL_REMOVE:
            begin
                // pull down from the right once the first match is at or left of here
                if (seen_out)
                    entry_next = right_entry;
            end
            CELL_LOAD:  tap_next = entry_reg;
            CELL_SHIFT: tap_next = right_tap;
            default:    ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tap_reg   <= tap_next;
    end

    assign entry = entry_reg;
    assign tap   = tap_reg;
endmodule

### rtl/core/rpnp_pcg.sv
`timescale 1ns / 1ps
// ============================================================================
// rpnp_pcg
// One generator step: 64-bit LCG advance on a shared 32x32 multiplier.
// ============================================================================
module rpnp_pcg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] old_state,
    output logic        done,
    output logic [63:0] new_state,
    output logic [31:0] rnd
);
    import rpnp_pkg::*;

    logic [63:0] old_reg;
    logic [63:0] new_reg;
    logic [63:0] p0_reg;
    logic [31:0] p1_reg, p2_reg;
    logic [2:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] mixed;
    logic [4:0]  rot;

    always_comb
    begin
        mul_a = old_reg[31:0];
        mul_b = PCG_MULT[31:0];
        case (step_reg)
            3'd1:    mul_b = PCG_MULT[63:32];
            3'd2:    mul_a = old_reg[63:32];
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 3'd0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            old_reg <= old_state;
        if (busy_reg)
        begin
            case (step_reg)
                3'd0: p0_reg <= mul_p;
                3'd1: p1_reg <= mul_p[31:0];
                3'd2: p2_reg <= mul_p[31:0];
                3'd3: new_reg <= p0_reg + {p1_reg + p2_reg, 32'd0} + PCG_INC;
                default: ;
            endcase
        end
    end

    // XSH-RR output from the state before the advance
    assign mixed = 32'(((old_reg >> 18) ^ old_reg) >> 27);
    assign rot   = old_reg[63:59];
    assign rnd   = (mixed >> rot) | (mixed << ((5'd0 - rot) & 5'd31));

    assign done      = done_reg;
    assign new_state = new_reg;
endmodule

### rtl/core/rpnp_div.sv
`timescale 1ns / 1ps
// ============================================================================
// rpnp_div
// 32-bit restoring divider, one quotient bit per cycle.
// ============================================================================
module rpnp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quot
);
    logic [31:0] den_reg;
    logic [31:0] qn_reg;
    logic [32:0] rem_reg;
    logic [32:0] rem_sh;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        fits;

    assign rem_sh = {rem_reg[31:0], qn_reg[31]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            qn_reg  <= num;
            rem_reg <= 33'd0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
            qn_reg  <= {qn_reg[30:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = qn_reg;
endmodule

### rtl/core/random_pick_note_pool_core.sv
`timescale 1ns / 1ps
// ============================================================================
// random_pick_note_pool_core
// Ordered note pool on a chain of cells with a PCG32 uniform random pick.
// ============================================================================
// Note, clear and unused commands and empty-pool picks: the result is registered
//   as the request is accepted. Pick: a range division, a generator step per
//   rejection try, an index division and an index-long tap shift.
// Seed write: the generator steps from the seed while requests are held off.
// Reset: count and insert position zero, generator seeded with a zero seed;
//   pool entries hold no defined value until written.
module random_pick_note_pool_core (
    input  logic       clk,
    input  logic       rst_n,
    rpnp_req_if.sink   req_in,
    rpnp_rsp_if.source rsp_out,
    rpnp_cfg_if.sink   cfg
);
    import rpnp_pkg::*;

    // ---------------------------------------------------------------- state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ipos_reg, ipos_next;
    logic             mode_reg;
    logic [63:0]      gen_reg;
    logic [31:0]      range_reg;
    logic [31:0]      limit_reg;
    logic [IDX_W-1:0] idx_reg;

    // result register
    logic                     rsp_valid_reg;
    logic signed [NOTE_W-1:0] picked_reg;
    logic                     pvalid_reg;
    logic [CNT_W-1:0]         rcount_reg;
    logic                     found_reg;
    logic                     ovf_reg;

    // ------------------------------------------------------------ handshakes
    logic req_fire, cfg_fire, rsp_free, long_pick;
    cmd_t cmd_in;

    assign cmd_in    = cmd_t'(req_in.cmd);
    assign rsp_free  = !rsp_valid_reg || rsp_out.ready;
    // a request is taken only while the result slot is free;
    // a pending register write goes first
    assign req_in.ready = (state_reg == ST_IDLE) && rsp_free && !cfg.valid;
    assign cfg.ready    = (state_reg == ST_IDLE);
    assign req_fire  = req_in.valid && req_in.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign long_pick = (cmd_in == CMD_PICK) && (count_reg != '0);

    // ------------------------------------------------------------ cell chain
    cell_ctrl_t               ctrl;
    logic signed [NOTE_W-1:0] entry [POOL_DEPTH];
    logic signed [NOTE_W-1:0] tap [POOL_DEPTH];
    logic                     seen [POOL_DEPTH+1];
    logic [CNT_W-1:0]         pos_eff;

    // restart at the front on a list start, clamp past removals
    always_comb
    begin
        pos_eff = req_in.list_start ? '0 : ipos_reg;
        if (pos_eff > count_reg)
            pos_eff = count_reg;
    end

    assign seen[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < POOL_DEPTH; g++)
        begin : g_cell
            logic signed [NOTE_W-1:0] left_e, right_e, right_t;
            if (g == 0)
            begin : g_first
                assign left_e = '0;
            end
            else
            begin : g_mid
                assign left_e = entry[g-1];
            end
            if (g == POOL_DEPTH - 1)
            begin : g_last
                assign right_e = '0;
                assign right_t = '0;
            end
            else
            begin : g_inner
                assign right_e = entry[g+1];
                assign right_t = tap[g+1];
            end
            rpnp_cell u_cell (
                .clk         (clk),
                .cell_idx    (IDX_W'(g)),
                .ctrl        (ctrl),
                .left_entry  (left_e),
                .right_entry (right_e),
                .right_tap   (right_t),
                .seen_in     (seen[g]),
                .seen_out    (seen[g+1]),
                .entry       (entry[g]),
                .tap         (tap[g])
            );
        end
    endgenerate

    // ------------------------------------------------- generator and divider
    logic        pcg_start, pcg_done;
    logic [63:0] pcg_old, pcg_new;
    logic [31:0] pcg_rnd;
    logic        div_start, div_done;
    logic [31:0] div_num, div_den, div_quot;

    // seed path: zero state steps to the increment, then the seed is added
    always_comb
    begin
        case (state_reg)
            ST_IDLE: pcg_old = PCG_INC + {32'd0, cfg.data};
            ST_GEN:  pcg_old = pcg_new;
            default: pcg_old = gen_reg;
        endcase
    end

    rpnp_pcg u_pcg (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pcg_start),
        .old_state (pcg_old),
        .done      (pcg_done),
        .new_state (pcg_new),
        .rnd       (pcg_rnd)
    );

    assign div_num = (state_reg == ST_IDLE) ? 32'hFFFF_FFFF : pcg_rnd;
    assign div_den = (state_reg == ST_IDLE) ? {{(32-CNT_W){1'b0}}, count_reg} : range_reg;

    rpnp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire && cfg_idx_t'(cfg.index) == CFG_SEED)
                    state_next = ST_SEED;
                else if (req_fire && long_pick)
                    state_next = ST_RANGE;
            end
            ST_SEED:  if (pcg_done) state_next = ST_IDLE;
            ST_RANGE: if (div_done) state_next = ST_LIMIT;
            ST_LIMIT: state_next = ST_GEN;
            ST_GEN:   if (pcg_done && pcg_rnd < limit_reg) state_next = ST_INDEX;
            ST_INDEX: if (div_done) state_next = ST_SHIFT;
            ST_SHIFT: if (idx_reg == '0) state_next = ST_FIN;
            ST_FIN:   if (rsp_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // --------------------------------------------------------------- outputs
    always_comb
    begin
        ctrl.op    = CELL_HOLD;
        ctrl.note  = req_in.note;
        ctrl.pos   = pos_eff;
        ctrl.count = count_reg;
        pcg_start  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire && cfg_idx_t'(cfg.index) == CFG_SEED)
                    pcg_start = 1'b1;
                else if (req_fire)
                begin
                    case (cmd_in)
                        CMD_NOTE:
                        begin
                            if (mode_reg)
                                ctrl.op = CELL_REMOVE;
                            else if (count_reg < CNT_W'(POOL_DEPTH))
                                ctrl.op = CELL_INSERT;
                        end
                        CMD_PICK:
                        begin
                            if (long_pick)
                            begin
                                ctrl.op   = CELL_LOAD;
                                div_start = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LIMIT: pcg_start = 1'b1;
            ST_GEN:
            begin
                if (pcg_done)
                begin
                    // retry on rejection, otherwise scale the draw down
                    if (pcg_rnd >= limit_reg)
                        pcg_start = 1'b1;
                    else
                        div_start = 1'b1;
                end
            end
            ST_SHIFT: if (idx_reg != '0) ctrl.op = CELL_SHIFT;
            default: ;
        endcase
    end

    // ------------------------------------------------------ count bookkeeping
    always_comb
    begin
        count_next = count_reg;
        ipos_next  = ipos_reg;
        if (req_fire)
        begin
            case (cmd_in)
                CMD_NOTE:
                begin
                    if (!mode_reg)
                    begin
                        ipos_next = pos_eff;
                        if (count_reg < CNT_W'(POOL_DEPTH))
                        begin
                            ipos_next  = pos_eff + CNT_W'(1);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (seen[POOL_DEPTH])
                        count_next = count_reg - CNT_W'(1);
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                    ipos_next  = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ipos_reg      <= '0;
            mode_reg      <= 1'b0;
            gen_reg       <= PCG_RESET_STATE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ipos_reg  <= ipos_next;
            if (cfg_fire && cfg_idx_t'(cfg.index) == CFG_REMOVE_MODE)
                mode_reg <= cfg.data[0];
            // take each finished step's advanced state
            if (pcg_done)
                gen_reg <= pcg_new;
            if (rsp_out.ready)
                rsp_valid_reg <= 1'b0;
            if ((req_fire && !long_pick) || (state_reg == ST_FIN && rsp_free))
                rsp_valid_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RANGE && div_done)
            range_reg <= div_quot;
        if (state_reg == ST_LIMIT)
            limit_reg <= 32'(range_reg * {{(32-CNT_W){1'b0}}, count_reg});
        if (state_reg == ST_INDEX && div_done)
        begin
            if (div_quot >= {{(32-CNT_W){1'b0}}, count_reg})
                idx_reg <= IDX_W'(count_reg - CNT_W'(1));
            else
                idx_reg <= div_quot[IDX_W-1:0];
        end
        else if (state_reg == ST_SHIFT && idx_reg != '0)
            idx_reg <= idx_reg - IDX_W'(1);

        if (req_fire && !long_pick)
        begin
            picked_reg <= '0;
            pvalid_reg <= 1'b0;
            rcount_reg <= count_next;
            found_reg  <= (cmd_in == CMD_NOTE) && mode_reg && seen[POOL_DEPTH];
            ovf_reg    <= (cmd_in == CMD_NOTE) && !mode_reg
                          && (count_reg >= CNT_W'(POOL_DEPTH));
        end
        else if (state_reg == ST_FIN && rsp_free)
        begin
            picked_reg <= tap[0];
            pvalid_reg <= 1'b1;
            rcount_reg <= count_reg;
            found_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
        end
    end

    assign rsp_out.valid       = rsp_valid_reg;
    assign rsp_out.picked_note = picked_reg;
    assign rsp_out.pick_valid  = pvalid_reg;
    assign rsp_out.entry_count = rcount_reg;
    assign rsp_out.note_found  = found_reg;
    assign rsp_out.overflow    = ovf_reg;
endmodule
